@@ rtl/pftp_pkg.sv @@
// ----------------------------------------------------------------------------
// pftp_pkg
// Shared default widths of the plane normal pipeline.
// ----------------------------------------------------------------------------
package pftp_pkg;

  localparam int unsigned CoordWidthDef = 16;
  localparam int unsigned FracBitsDef   = 15;

endpackage

@@ rtl/pftp_if.sv @@
// ----------------------------------------------------------------------------
// pftp_if
// Valid/ready channel carrying a generic payload of parameterised width.
// ----------------------------------------------------------------------------
interface pftp_if #(
  parameter int unsigned W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/pftp_cell.sv @@
// ----------------------------------------------------------------------------
// pftp_cell
// One step of a shared-shape cell: either one root bit or one quotient bit for each
// of the three components, passed to the next cell with a valid bit.
// ----------------------------------------------------------------------------
module pftp_cell #(
  parameter int unsigned SW = 68,
  parameter int unsigned RW = 34,
  parameter int unsigned MW = 35,
  parameter int unsigned QW = 16,
  parameter int unsigned PW = 48,
  parameter int unsigned ROOT_STEP = 1,
  parameter int unsigned BIT = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [SW-1:0] s_i,
  input  logic [RW-1:0] r_i,
  input  logic [MW-1:0] mx_i, my_i, mz_i,
  input  logic [QW-1:0] qx_i, qy_i, qz_i,
  input  logic [MW:0]   rx_i, ry_i, rz_i,
  input  logic [2:0]    sg_i,
  input  logic [PW-1:0] pass_i,
  output logic          vld_o,
  output logic [SW-1:0] s_o,
  output logic [RW-1:0] r_o,
  output logic [MW-1:0] mx_o, my_o, mz_o,
  output logic [QW-1:0] qx_o, qy_o, qz_o,
  output logic [MW:0]   rx_o, ry_o, rz_o,
  output logic [2:0]    sg_o,
  output logic [PW-1:0] pass_o
);
  localparam int unsigned MB = (BIT < MW) ? BIT : 0;

  logic [RW-1:0]   t;
  logic [2*RW-1:0] sq;
  logic [RW-1:0]   r_d;
  logic [MW+1:0]   ax, ay, az;
  logic [QW-1:0]   qx_d, qy_d, qz_d;
  logic [MW:0]     rx_d, ry_d, rz_d;

  always_comb begin
    t    = r_i;
    r_d  = r_i;
    qx_d = qx_i; qy_d = qy_i; qz_d = qz_i;
    rx_d = rx_i; ry_d = ry_i; rz_d = rz_i;
    ax = '0; ay = '0; az = '0;
    sq = '0;
    if (ROOT_STEP != 0) begin
      t[BIT] = 1'b1;
      sq = t * t;
      if (s_i >= sq) r_d = t;
    end else begin
      ax = {rx_i, 1'b0};
      ay = {ry_i, 1'b0};
      az = {rz_i, 1'b0};
      if (BIT < MW) begin
        ax[0] = mx_i[MB]; ay[0] = my_i[MB]; az[0] = mz_i[MB];
      end
      qx_d = {qx_i[QW-2:0], 1'b0};
      qy_d = {qy_i[QW-2:0], 1'b0};
      qz_d = {qz_i[QW-2:0], 1'b0};
      if (ax >= {1'b0, r_i}) begin
        ax = ax - {1'b0, r_i}; qx_d[0] = 1'b1;
      end
      if (ay >= {1'b0, r_i}) begin
        ay = ay - {1'b0, r_i}; qy_d[0] = 1'b1;
      end
      if (az >= {1'b0, r_i}) begin
        az = az - {1'b0, r_i}; qz_d[0] = 1'b1;
      end
      rx_d = ax[MW:0]; ry_d = ay[MW:0]; rz_d = az[MW:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_o <= s_i; r_o <= r_d;
      mx_o <= mx_i; my_o <= my_i; mz_o <= mz_i;
      qx_o <= qx_d; qy_o <= qy_d; qz_o <= qz_d;
      rx_o <= rx_d; ry_o <= ry_d; rz_o <= rz_d;
      sg_o <= sg_i; pass_o <= pass_i;
    end
  end
endmodule

@@ rtl/plane_from_three_points.sv @@
// ----------------------------------------------------------------------------
// plane_from_three_points
// Unit normal of the plane through three points, with the second point as
// anchor and a flag for collinear points.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in      | in  | three points, 9 x COORD_WIDTH
//  out     | out | normal x/y/z, anchor x/y/z, degenerate
// One beat enters per cycle unless the output is stalled; each beat passes through
// the front stages, the chain of one-bit root cells and one-bit divide cells
// (divide steps: magnitude bits plus fraction bits), and the output register.
// The whole chain advances together and holds while the output is stalled.
// Reset clears the valid bits only.
module plane_from_three_points #(
  parameter int unsigned COORD_WIDTH      = pftp_pkg::CoordWidthDef,
  parameter int unsigned NORMAL_FRAC_BITS = pftp_pkg::FracBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  pftp_if.sink   in_i,
  pftp_if.source out_o
);
  import pftp_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned DW = CW + 1;
  localparam int unsigned MW = 2 * DW + 1;
  localparam int unsigned SW = 2 * MW + 2;
  localparam int unsigned RW = SW / 2;
  localparam int unsigned QW = NORMAL_FRAC_BITS + 1;
  localparam int unsigned NB = MW + NORMAL_FRAC_BITS;
  localparam int unsigned NC = RW + NB;
  localparam int unsigned PW = 3 * CW;
  localparam int unsigned OW = 3 * QW + 3 * CW + 1;

  logic en;
  logic [OW-1:0] obuf_q;
  logic          ovld_q;

  // stage 1: differences
  logic                 v1_q;
  logic signed [DW-1:0] ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;
  logic [PW-1:0]        p1_q;
  // stage 2: products
  logic                   v2_q;
  logic signed [2*DW-1:0] pa_q [6];
  logic [PW-1:0]          p2_q;
  // stage 3: magnitudes and signs
  logic           v3_q;
  logic [MW-1:0]  m_q [3];
  logic [2:0]     sg3_q;
  logic [PW-1:0]  p3_q;
  logic [MW-1:0]  m3_d [3];
  logic signed [MW-1:0] c3 [3];
  // stage 4: squares (the sum is registered after them)
  logic          v4_q;
  logic [SW-1:0] s4_q;
  logic [MW-1:0] m4_q [3];
  logic [2:0]    sg4_q;
  logic [PW-1:0] p4_q;
  logic [2*MW-1:0] sq_q [3];

  logic          cv  [NC+1];
  logic [SW-1:0] cs  [NC+1];
  logic [RW-1:0] cr  [NC+1];
  logic [MW-1:0] cmx [NC+1], cmy [NC+1], cmz [NC+1];
  logic [QW-1:0] cqx [NC+1], cqy [NC+1], cqz [NC+1];
  logic [MW:0]   crx [NC+1], cry [NC+1], crz [NC+1];
  logic [2:0]    csg [NC+1];
  logic [PW-1:0] cp  [NC+1];

  assign en = !ovld_q || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
    end
  end

  always_comb begin
    c3[0] = MW'(pa_q[0]) - MW'(pa_q[1]);
    c3[1] = MW'(pa_q[2]) - MW'(pa_q[3]);
    c3[2] = MW'(pa_q[4]) - MW'(pa_q[5]);
    for (int i = 0; i < 3; i++) m3_d[i] = c3[i][MW-1] ? MW'(-c3[i]) : MW'(c3[i]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ux_q <= DW'($signed(in_i.data[4*CW-1:3*CW])) - DW'($signed(in_i.data[CW-1:0]));
      uy_q <= DW'($signed(in_i.data[5*CW-1:4*CW])) - DW'($signed(in_i.data[2*CW-1:CW]));
      uz_q <= DW'($signed(in_i.data[6*CW-1:5*CW])) - DW'($signed(in_i.data[3*CW-1:2*CW]));
      vx_q <= DW'($signed(in_i.data[7*CW-1:6*CW])) - DW'($signed(in_i.data[CW-1:0]));
      vy_q <= DW'($signed(in_i.data[8*CW-1:7*CW])) - DW'($signed(in_i.data[2*CW-1:CW]));
      vz_q <= DW'($signed(in_i.data[9*CW-1:8*CW])) - DW'($signed(in_i.data[3*CW-1:2*CW]));
      p1_q <= in_i.data[6*CW-1:3*CW];
      pa_q[0] <= uy_q * vz_q; pa_q[1] <= vy_q * uz_q;
      pa_q[2] <= uz_q * vx_q; pa_q[3] <= vz_q * ux_q;
      pa_q[4] <= ux_q * vy_q; pa_q[5] <= vx_q * uy_q;
      p2_q <= p1_q;
      for (int i = 0; i < 3; i++) m_q[i] <= m3_d[i];
      sg3_q <= {c3[2][MW-1], c3[1][MW-1], c3[0][MW-1]};
      p3_q <= p2_q;
      for (int i = 0; i < 3; i++) sq_q[i] <= m_q[i] * m_q[i];
      s4_q <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
      for (int i = 0; i < 3; i++) m4_q[i] <= m_q[i];
      sg4_q <= sg3_q;
      p4_q <= p3_q;
    end
  end

  // hold magnitudes, signs and anchor one more stage to line up with the sum
  logic [MW-1:0] m5_q [3];
  logic [2:0]    sg5_q;
  logic [PW-1:0] p5_q;
  logic          v5_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sg5_q <= sg4_q; p5_q <= p4_q;
      for (int i = 0; i < 3; i++) m5_q[i] <= m4_q[i];
    end
  end
  assign cv[0]  = v5_q;
  assign cs[0]  = s4_q;
  assign cr[0]  = '0;
  assign cmx[0] = m5_q[0];
  assign cmy[0] = m5_q[1];
  assign cmz[0] = m5_q[2];
  assign cqx[0] = '0; assign cqy[0] = '0; assign cqz[0] = '0;
  assign crx[0] = '0; assign cry[0] = '0; assign crz[0] = '0;
  assign csg[0] = sg5_q;
  assign cp[0]  = p5_q;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    pftp_cell #(
      .SW(SW), .RW(RW), .MW(MW), .QW(QW), .PW(PW),
      .ROOT_STEP(k < RW ? 1 : 0),
      .BIT(k < RW ? RW - 1 - k : ((k - RW) < MW ? MW - 1 - (k - RW) : MW))
    ) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .vld_i(cv[k]), .s_i(cs[k]), .r_i(cr[k]),
      .mx_i(cmx[k]), .my_i(cmy[k]), .mz_i(cmz[k]),
      .qx_i(cqx[k]), .qy_i(cqy[k]), .qz_i(cqz[k]),
      .rx_i(crx[k]), .ry_i(cry[k]), .rz_i(crz[k]),
      .sg_i(csg[k]), .pass_i(cp[k]),
      .vld_o(cv[k+1]), .s_o(cs[k+1]), .r_o(cr[k+1]),
      .mx_o(cmx[k+1]), .my_o(cmy[k+1]), .mz_o(cmz[k+1]),
      .qx_o(cqx[k+1]), .qy_o(cqy[k+1]), .qz_o(cqz[k+1]),
      .rx_o(crx[k+1]), .ry_o(cry[k+1]), .rz_o(crz[k+1]),
      .sg_o(csg[k+1]), .pass_o(cp[k+1])
    );
  end

  function automatic logic [QW-1:0] fin(input logic [QW-1:0] q, input logic neg);
    logic [QW-1:0] lim;
    logic [QW-1:0] m;
    lim = {1'b0, {(QW-1){1'b1}}};
    m = (q > lim) ? lim : q;
    fin = neg ? QW'(-m) : m;
  endfunction

  logic deg;
  assign deg = (cs[NC] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovld_q <= 1'b0;
    else if (en) ovld_q <= cv[NC];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      obuf_q <= deg ? {{(3*QW){1'b0}}, cp[NC], 1'b1}
                    : {fin(cqz[NC], csg[NC][2]), fin(cqy[NC], csg[NC][1]),
                       fin(cqx[NC], csg[NC][0]), cp[NC], 1'b0};
    end
  end

  assign out_o.valid = ovld_q;
  assign out_o.data  = obuf_q;

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.data))
    else $error("output beat changed while stalled");
  a_deg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data[0] |-> out_o.data[OW-1:PW+1] == '0)
    else $error("degenerate beat with nonzero normal");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled with empty output");
`endif
endmodule
